// ===== rtl/core/obcrd_pkg.sv =====
// Shared types and constants for the obstacle confirm/release debounce core.
`timescale 1ns / 1ps

package obcrd_pkg;

    // Field widths fixed by the interface definition.
    localparam int unsigned TIME_W = 32;
    localparam int unsigned DIST_W = 10;
    localparam int unsigned MS_W   = 16;

    // Packed beat widths on the two stream channels.
    localparam int unsigned IN_ITEM_W  = TIME_W + 1 + DIST_W + 1 + DIST_W;
    localparam int unsigned IN_TDATA_W = ((IN_ITEM_W + 7) / 8) * 8;
    localparam int unsigned RESULT_W   = 4;
    localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // Configuration port widths.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = MS_W;

    // Register reset values.
    localparam logic [MS_W-1:0]   WARMUP_RST  = MS_W'(500);
    localparam logic [DIST_W-1:0] DIST_RST    = DIST_W'(20);
    localparam logic [MS_W-1:0]   CONFIRM_RST = MS_W'(100);
    localparam logic [MS_W-1:0]   RELEASE_RST = MS_W'(300);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WARMUP_MS   = 2'd0,
        CFG_OBST_DIST   = 2'd1,
        CFG_CONFIRM_MS  = 2'd2,
        CFG_RELEASE_MS  = 2'd3
    } cfg_idx_t;

    // Current configuration, handed from the register bank to the update logic.
    typedef struct packed {
        logic [MS_W-1:0]   warmup_ms;
        logic [DIST_W-1:0] obstacle_distance_cm;
        logic [MS_W-1:0]   confirm_ms;
        logic [MS_W-1:0]   release_ms;
    } cfg_t;

    // One input item, first field in the lowest bits.
    typedef struct packed {
        logic [DIST_W-1:0] right_distance_cm;
        logic              right_valid;
        logic [DIST_W-1:0] left_distance_cm;
        logic              left_valid;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    // One result item, first field in the lowest bit.
    typedef struct packed {
        logic obstacle_latched;
        logic near_right;
        logic near_left;
        logic sensors_ready;
    } result_t;

endpackage

// ===== rtl/core/obcrd_cfg_regs.sv =====
// Configuration register bank for the obstacle debounce core.
`timescale 1ns / 1ps

module obcrd_cfg_regs
    import obcrd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and merge the written value.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (cfg_idx_t'(wr_index))
                CFG_WARMUP_MS:  cfg_next.warmup_ms            = wr_data;
                CFG_OBST_DIST:  cfg_next.obstacle_distance_cm = wr_data[DIST_W-1:0];
                CFG_CONFIRM_MS: cfg_next.confirm_ms           = wr_data;
                CFG_RELEASE_MS: cfg_next.release_ms           = wr_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank with its reset defaults.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warmup_ms            <= WARMUP_RST;
            cfg_reg.obstacle_distance_cm <= DIST_RST;
            cfg_reg.confirm_ms           <= CONFIRM_RST;
            cfg_reg.release_ms           <= RELEASE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/obcrd_update.sv =====
// Detection, warmup and confirm/release latch logic with its timing state.
`timescale 1ns / 1ps

module obcrd_update
    import obcrd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  in_item_t item,
    input  cfg_t     cfg,
    output result_t  result
);

    logic [TIME_W-1:0] ready_stamp_reg, ready_stamp_next;
    logic [TIME_W-1:0] detect_start_reg, detect_start_next;
    logic [TIME_W-1:0] clear_start_reg, clear_start_next;
    logic              latch_reg, latch_next;

    logic [TIME_W-1:0] stamp_eff;
    logic [TIME_W-1:0] detect_eff;
    logic [TIME_W-1:0] clear_eff;
    logic [TIME_W-1:0] warm_age;
    logic [TIME_W-1:0] detect_age;
    logic [TIME_W-1:0] clear_age;
    logic              ready;
    logic              near_l;
    logic              near_r;
    logic              seen;
    logic              confirm_hit;
    logic              release_hit;

    // Warmup: the stamp is taken on the first beat with any valid reading.
    always_comb begin
        stamp_eff = ready_stamp_reg;
        if ((ready_stamp_reg == '0) && (item.left_valid || item.right_valid)) begin
            stamp_eff = item.now_ms;
        end
        warm_age = item.now_ms - stamp_eff;
        ready    = (stamp_eff != '0) && (warm_age > {{(TIME_W-MS_W){1'b0}}, cfg.warmup_ms});
    end

    // Instantaneous detection on each side.
    assign near_l = ready && item.left_valid
                    && (item.left_distance_cm < cfg.obstacle_distance_cm);
    assign near_r = ready && item.right_valid
                    && (item.right_distance_cm < cfg.obstacle_distance_cm);
    assign seen   = near_l || near_r;

    // Run start times, with a zero stamp replaced by the current time.
    assign detect_eff  = (detect_start_reg == '0) ? item.now_ms : detect_start_reg;
    assign clear_eff   = (clear_start_reg == '0) ? item.now_ms : clear_start_reg;
    assign detect_age  = item.now_ms - detect_eff;
    assign clear_age   = item.now_ms - clear_eff;
    assign confirm_hit = detect_age >= {{(TIME_W-MS_W){1'b0}}, cfg.confirm_ms};
    assign release_hit = clear_age >= {{(TIME_W-MS_W){1'b0}}, cfg.release_ms};

    // Confirm and release timing around the obstacle latch.
    always_comb begin
        ready_stamp_next  = stamp_eff;
        detect_start_next = detect_start_reg;
        clear_start_next  = clear_start_reg;
        latch_next        = latch_reg;
        if (!latch_reg) begin
            if (seen) begin
                detect_start_next = detect_eff;
                if (confirm_hit) begin
                    latch_next        = 1'b1;
                    clear_start_next  = '0;
                    detect_start_next = '0;
                end
            end else begin
                detect_start_next = '0;
            end
        end else begin
            if (seen) begin
                clear_start_next = '0;
            end else begin
                clear_start_next = clear_eff;
                if (release_hit) begin
                    latch_next       = 1'b0;
                    clear_start_next = '0;
                end
            end
        end
    end

    // Timing state moves only when an item is processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_stamp_reg  <= '0;
            detect_start_reg <= '0;
            clear_start_reg  <= '0;
            latch_reg        <= 1'b0;
        end else if (step) begin
            ready_stamp_reg  <= ready_stamp_next;
            detect_start_reg <= detect_start_next;
            clear_start_reg  <= clear_start_next;
            latch_reg        <= latch_next;
        end
    end

    assign result.sensors_ready    = ready;
    assign result.near_left        = near_l;
    assign result.near_right       = near_r;
    assign result.obstacle_latched = latch_next;

endmodule

// ===== rtl/core/obstacle_confirm_release_debounce_core.sv =====
// Top level of the obstacle confirm/release debounce core.
`timescale 1ns / 1ps

// The core takes one sensor update per beat and returns one result beat per
// update, in order. It accepts a new beat every cycle while results are
// taken; a result passes through the input register and the result register
// around the update logic. The timing state (ready stamp, detection and
// absence run starts, obstacle latch) is updated in the same cycle that the
// result is formed, so consecutive beats see each other's effects without
// gaps. The user must write configuration registers through the cfg port
// only while no beat is in flight; the core does not enforce this. The cfg
// port is always ready.
module obstacle_confirm_release_debounce_core
    import obcrd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata, low bit up: now_ms[31:0], left_valid, left_distance_cm[9:0],
    // right_valid, right_distance_cm[9:0], zero fill.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata, low bit up: sensors_ready, near_left, near_right,
    // obstacle_latched, zero fill.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     out_valid_reg;
    result_t  out_data_reg;
    logic     advance;
    cfg_t     cfg;
    result_t  result;

    // The input register moves on whenever the result register is free or drained.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_item_reg <= in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
        end
    end

    obcrd_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    obcrd_update u_update (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_data_reg};

endmodule

// ===== rtl/core/obcrd_checker.sv =====
// Port-level checks for the obstacle debounce core, bound to its top level.
`timescale 1ns / 1ps

module obcrd_checker
    import obcrd_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // No result beat is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result beat offered straight after reset");

    // A side can only be near once the sensors are ready.
    a_near_needs_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata[1] || m_axis_tdata[2])) |-> m_axis_tdata[0])
        else $error("near flag without sensors ready");

    // With no result waiting, the input side must take a beat.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // A stalled result beat holds its data.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

endmodule

bind obstacle_confirm_release_debounce_core obcrd_checker u_obcrd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
